// File: sv/srfc_pkg.sv
// ----------------------------------------------------------------------------
// srfc_pkg
// Shared types and constants for the sensor reply frame checker.
// ----------------------------------------------------------------------------
package srfc_pkg;

    localparam int unsigned MAX_BUFFER = 128;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned SUM_W      = 16;
    localparam int unsigned POS_W      = 18;

    localparam logic [7:0] HDR0_BYTE  = 8'hEF;
    localparam logic [7:0] HDR1_BYTE  = 8'h01;
    localparam logic [7:0] PID_BYTE   = 8'h07;
    localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;

    localparam logic [CNT_W-1:0] POS_ADDR0   = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_ADDR1   = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_ADDR2   = CNT_W'(4);
    localparam logic [CNT_W-1:0] POS_ADDR3   = CNT_W'(5);
    localparam logic [CNT_W-1:0] POS_PID     = CNT_W'(6);
    localparam logic [CNT_W-1:0] POS_LEN_HI  = CNT_W'(7);
    localparam logic [CNT_W-1:0] POS_LEN_LO  = CNT_W'(8);
    localparam logic [CNT_W-1:0] POS_CONFIRM = CNT_W'(9);
    localparam logic [CNT_W-1:0] POS_PAR_HI  = CNT_W'(10);
    localparam logic [CNT_W-1:0] POS_PAR_LO  = CNT_W'(11);
    localparam logic [CNT_W-1:0] FIXED_PART  = CNT_W'(9);
    localparam logic [CNT_W-1:0] CNT_MAX     = CNT_W'(MAX_BUFFER);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_HEADER   = 2'd1,
        ST_LENGTH   = 2'd2,
        ST_CHECKSUM = 2'd3
    } status_t;

endpackage

// File: sv/srfc_if.sv
// ----------------------------------------------------------------------------
// srfc_if
// Valid/ready channels for received bytes and frame check results.
// ----------------------------------------------------------------------------
interface srfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface srfc_out_if;
    logic              valid;
    logic              ready;
    srfc_pkg::status_t status;
    logic [7:0]        confirm_code;
    logic [15:0]       first_param;
    logic [15:0]       declared_len;

    modport source (output valid, output status, output confirm_code,
                    output first_param, output declared_len, input ready);
    modport sink   (input valid, input status, input confirm_code,
                    input first_param, input declared_len, output ready);
endinterface

// File: sv/sensor_reply_frame_checker.sv
// ----------------------------------------------------------------------------
// sensor_reply_frame_checker
// Checks a received reply buffer byte by byte: header, address, length and
// 16-bit wrapping checksum; reports one result per buffer on its last byte.
// ----------------------------------------------------------------------------
// Result: valid in the cycle after the transfer of the last byte.
// Throughput: one byte per cycle; the per-byte state registers update on each
//   transfer, and a held result stalls input only while it is not taken.
// Reset: frame state cleared, no result pending, expected address FFFFFFFF.
module sensor_reply_frame_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    srfc_in_if.sink            in_ch,
    srfc_out_if.source         out_ch
);

    logic [31:0]                  expected_address_reg;
    logic [srfc_pkg::CNT_W-1:0]   byte_count_reg,   byte_count_next;
    logic [15:0]                  length_field_reg, length_field_next;
    logic [srfc_pkg::SUM_W-1:0]   running_sum_reg,  running_sum_next;
    logic [7:0]                   sum_high_reg,     sum_high_next;
    srfc_pkg::status_t            first_error_reg,  first_error_next;
    logic [7:0]                   confirm_reg,      confirm_next;
    logic [15:0]                  param_reg,        param_next;

    logic                         out_valid_reg;
    srfc_pkg::status_t            out_status_reg,   status_next;
    logic [7:0]                   out_confirm_reg;
    logic [15:0]                  out_param_reg;
    logic [15:0]                  out_len_reg;

    logic                         in_fire;
    logic                         keep_byte;
    logic [7:0]                   hdr_byte;
    logic [srfc_pkg::POS_W-1:0]   pos_w;
    logic [srfc_pkg::POS_W-1:0]   len_w;
    logic [srfc_pkg::POS_W-1:0]   cnt_w;
    logic [srfc_pkg::POS_W-1:0]   len_next_w;
    logic [15:0]                  got_sum;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign keep_byte   = byte_count_reg < srfc_pkg::CNT_MAX;

    assign pos_w      = srfc_pkg::POS_W'(byte_count_reg);
    assign len_w      = srfc_pkg::POS_W'(length_field_reg);
    assign got_sum    = {sum_high_reg, in_ch.byte_value};

    always_comb
    begin
        unique case (byte_count_reg)
            8'd0:                 hdr_byte = srfc_pkg::HDR0_BYTE;
            8'd1:                 hdr_byte = srfc_pkg::HDR1_BYTE;
            srfc_pkg::POS_ADDR0:  hdr_byte = expected_address_reg[31:24];
            srfc_pkg::POS_ADDR1:  hdr_byte = expected_address_reg[23:16];
            srfc_pkg::POS_ADDR2:  hdr_byte = expected_address_reg[15:8];
            srfc_pkg::POS_ADDR3:  hdr_byte = expected_address_reg[7:0];
            default:              hdr_byte = srfc_pkg::PID_BYTE;
        endcase
    end

    // per-byte frame state update
    always_comb
    begin
        byte_count_next   = byte_count_reg;
        length_field_next = length_field_reg;
        running_sum_next  = running_sum_reg;
        sum_high_next     = sum_high_reg;
        first_error_next  = first_error_reg;
        confirm_next      = confirm_reg;
        param_next        = param_reg;
        if (keep_byte)
        begin
            byte_count_next = byte_count_reg + 1'b1;
            if (byte_count_reg <= srfc_pkg::POS_PID && in_ch.byte_value != hdr_byte &&
                first_error_reg == srfc_pkg::ST_OK)
                first_error_next = srfc_pkg::ST_HEADER;
            if (byte_count_reg == srfc_pkg::POS_LEN_HI)
                length_field_next[15:8] = in_ch.byte_value;
            if (byte_count_reg == srfc_pkg::POS_LEN_LO)
                length_field_next[7:0] = in_ch.byte_value;
            if (byte_count_reg == srfc_pkg::POS_CONFIRM)
                confirm_next = in_ch.byte_value;
            if (byte_count_reg == srfc_pkg::POS_PAR_HI)
                param_next[15:8] = in_ch.byte_value;
            if (byte_count_reg == srfc_pkg::POS_PAR_LO)
                param_next[7:0] = in_ch.byte_value;

            if (byte_count_reg >= srfc_pkg::POS_PID && byte_count_reg <= srfc_pkg::POS_LEN_LO)
                running_sum_next = running_sum_reg + srfc_pkg::SUM_W'(in_ch.byte_value);
            else if (byte_count_reg > srfc_pkg::POS_LEN_LO && length_field_reg >= 16'd2)
            begin
                priority if (pos_w <= len_w + srfc_pkg::POS_W'(6))
                    running_sum_next = running_sum_reg + srfc_pkg::SUM_W'(in_ch.byte_value);
                else if (pos_w == len_w + srfc_pkg::POS_W'(7))
                    sum_high_next = in_ch.byte_value;
                else if (pos_w == len_w + srfc_pkg::POS_W'(8))
                begin
                    if (got_sum != running_sum_reg && first_error_reg == srfc_pkg::ST_OK)
                        first_error_next = srfc_pkg::ST_CHECKSUM;
                end
                else
                    sum_high_next = sum_high_reg;
            end
        end
    end

    assign cnt_w      = srfc_pkg::POS_W'(byte_count_next);
    assign len_next_w = srfc_pkg::POS_W'(length_field_next);

    always_comb
    begin
        priority if (first_error_next == srfc_pkg::ST_HEADER ||
                     byte_count_next < srfc_pkg::POS_LEN_HI)
            status_next = srfc_pkg::ST_HEADER;
        else if (byte_count_next < srfc_pkg::FIXED_PART || length_field_next < 16'd2 ||
                 cnt_w < len_next_w + srfc_pkg::POS_W'(srfc_pkg::FIXED_PART))
            status_next = srfc_pkg::ST_LENGTH;
        else if (first_error_next == srfc_pkg::ST_CHECKSUM)
            status_next = srfc_pkg::ST_CHECKSUM;
        else
            status_next = srfc_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expected_address_reg <= srfc_pkg::ADDR_RESET;
        else if (cfg_we)
            expected_address_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            length_field_reg <= '0;
            running_sum_reg  <= '0;
            sum_high_reg     <= '0;
            first_error_reg  <= srfc_pkg::ST_OK;
            confirm_reg      <= '0;
            param_reg        <= '0;
        end
        else if (in_fire)
        begin
            if (in_ch.last_byte)
            begin
                byte_count_reg   <= '0;
                length_field_reg <= '0;
                running_sum_reg  <= '0;
                sum_high_reg     <= '0;
                first_error_reg  <= srfc_pkg::ST_OK;
                confirm_reg      <= '0;
                param_reg        <= '0;
            end
            else
            begin
                byte_count_reg   <= byte_count_next;
                length_field_reg <= length_field_next;
                running_sum_reg  <= running_sum_next;
                sum_high_reg     <= sum_high_next;
                first_error_reg  <= first_error_next;
                confirm_reg      <= confirm_next;
                param_reg        <= param_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire && in_ch.last_byte)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.last_byte)
        begin
            out_status_reg  <= status_next;
            out_confirm_reg <= confirm_next;
            out_param_reg   <= param_next;
            out_len_reg     <= length_field_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.confirm_code = out_confirm_reg;
    assign out_ch.first_param  = out_param_reg;
    assign out_ch.declared_len = out_len_reg;

    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_ch.last_byte |=> out_valid_reg)
        else $error("no result after last byte transfer");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_ch.last_byte |=> byte_count_reg == '0 && first_error_reg == srfc_pkg::ST_OK)
        else $error("frame state not cleared after last byte");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= srfc_pkg::CNT_MAX)
        else $error("byte count beyond buffer size");

    a_no_length_flag: assert property (@(posedge clk) disable iff (!rst_n)
        first_error_reg != srfc_pkg::ST_LENGTH)
        else $error("length error latched in frame state");

endmodule

// File: sim/sensor_reply_frame_checker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_reply_frame_checker_tb
// Sends reply buffers byte by byte: a directed set of good frames and each
// error case, then random buffers, mostly well-formed frames with random
// bodies plus corrupted, truncated, overlong and noise buffers, over several
// expected addresses. A scoreboard tracks the frame state of every accepted
// byte and compares each reported result field by field.
// ----------------------------------------------------------------------------
module sensor_reply_frame_checker_tb;

    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef logic [7:0] octet_q_t[$];

    typedef struct packed {
        srfc_pkg::status_t status;
        logic [7:0]        confirm_code;
        logic [15:0]       first_param;
        logic [15:0]       declared_len;
    } frame_report_t;

    typedef enum {
        FK_GOOD,
        FK_BAD_SUM,
        FK_BAD_HEADER,
        FK_TRUNCATED,
        FK_SMALL_LEN,
        FK_OVERFLOW,
        FK_NOISE
    } frame_kind_t;

    class reply_frame_tracker;
        logic [31:0]       address;
        logic [7:0]        kept;
        logic [15:0]       len_field;
        logic [15:0]       sum;
        logic [7:0]        sum_hi;
        logic [7:0]        confirm;
        logic [15:0]       param;
        srfc_pkg::status_t err;
        frame_report_t     expected_q[$];
        int                failures;

        function new();
            address  = srfc_pkg::ADDR_RESET;
            failures = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            kept      = '0;
            len_field = '0;
            sum       = '0;
            sum_hi    = '0;
            confirm   = '0;
            param     = '0;
            err       = srfc_pkg::ST_OK;
        endfunction

        function logic [7:0] header_at(int unsigned pos);
            case (pos)
                0:                 return srfc_pkg::HDR0_BYTE;
                1:                 return srfc_pkg::HDR1_BYTE;
                srfc_pkg::POS_PID: return srfc_pkg::PID_BYTE;
                default:           return 8'(address >> (8 * (srfc_pkg::POS_ADDR3 - pos)));
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            int unsigned   pos;
            int unsigned   len;
            frame_report_t r;
            if (kept < srfc_pkg::CNT_MAX)
            begin
                pos = kept;
                if (pos <= srfc_pkg::POS_PID && b != header_at(pos) && err == srfc_pkg::ST_OK)
                    err = srfc_pkg::ST_HEADER;
                if (pos == srfc_pkg::POS_LEN_HI)  len_field[15:8] = b;
                if (pos == srfc_pkg::POS_LEN_LO)  len_field[7:0]  = b;
                if (pos == srfc_pkg::POS_CONFIRM) confirm         = b;
                if (pos == srfc_pkg::POS_PAR_HI)  param[15:8]     = b;
                if (pos == srfc_pkg::POS_PAR_LO)  param[7:0]      = b;
                len = len_field;
                if (pos >= srfc_pkg::POS_PID && pos <= srfc_pkg::POS_LEN_LO)
                    sum = sum + 16'(b);
                else if (pos > srfc_pkg::POS_LEN_LO && len >= 2)
                begin
                    if (pos <= srfc_pkg::POS_PID + len)
                        sum = sum + 16'(b);
                    else if (pos == srfc_pkg::POS_LEN_HI + len)
                        sum_hi = b;
                    else if (pos == srfc_pkg::POS_LEN_LO + len && {sum_hi, b} != sum &&
                             err == srfc_pkg::ST_OK)
                        err = srfc_pkg::ST_CHECKSUM;
                end
                kept++;
            end
            if (!last)
                return;
            len = len_field;
            if (err == srfc_pkg::ST_HEADER || kept <= srfc_pkg::POS_PID)
                r.status = srfc_pkg::ST_HEADER;
            else if (kept < srfc_pkg::FIXED_PART || len < 2 ||
                     kept < int'(srfc_pkg::FIXED_PART) + len)
                r.status = srfc_pkg::ST_LENGTH;
            else
                r.status = (err == srfc_pkg::ST_CHECKSUM) ? srfc_pkg::ST_CHECKSUM
                                                          : srfc_pkg::ST_OK;
            r.confirm_code = confirm;
            r.first_param  = param;
            r.declared_len = len_field;
            expected_q.push_back(r);
            clear_frame();
        endfunction

        function void check_report(srfc_pkg::status_t st, logic [7:0] cc, logic [15:0] fp,
                                   logic [15:0] dl);
            frame_report_t r;
            if (expected_q.size() == 0)
            begin
                $error("result transfer with no buffer pending");
                failures++;
                return;
            end
            r = expected_q.pop_front();
            if (st !== r.status)
            begin
                $error("status: expected %0d, got %0d", r.status, st);
                failures++;
            end
            if (cc !== r.confirm_code)
            begin
                $error("confirm_code: expected %02h, got %02h", r.confirm_code, cc);
                failures++;
            end
            if (fp !== r.first_param)
            begin
                $error("first_param: expected %04h, got %04h", r.first_param, fp);
                failures++;
            end
            if (dl !== r.declared_len)
            begin
                $error("declared_len: expected %04h, got %04h", r.declared_len, dl);
                failures++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [31:0] cfg_wdata;

    srfc_in_if  in_ch();
    srfc_out_if out_ch();

    sensor_reply_frame_checker dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    reply_frame_tracker tracker = new();
    int unsigned cycle_count = 0;
    int unsigned bytes_sent  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // idle-free windows: one quarter of the time
    function automatic int pick_gap();
        int r;
        if (cycle_count[10:9] == 2'b11)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic octet_q_t random_bytes(int unsigned n);
        octet_q_t q;
        repeat (n) q.push_back(8'($urandom));
        return q;
    endfunction

    function automatic octet_q_t build_frame(logic [31:0] addr, logic [15:0] len,
                                             octet_q_t body);
        octet_q_t    f;
        logic [15:0] s;
        f = {srfc_pkg::HDR0_BYTE, srfc_pkg::HDR1_BYTE, addr[31:24], addr[23:16],
             addr[15:8], addr[7:0], srfc_pkg::PID_BYTE, len[15:8], len[7:0]};
        s = 16'(srfc_pkg::PID_BYTE) + 16'(len[15:8]) + 16'(len[7:0]);
        foreach (body[i])
        begin
            f.push_back(body[i]);
            s = s + 16'(body[i]);
        end
        f.push_back(s[15:8]);
        f.push_back(s[7:0]);
        return f;
    endfunction

    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 64) return FK_GOOD;
        if (r < 72) return FK_BAD_SUM;
        if (r < 78) return FK_BAD_HEADER;
        if (r < 84) return FK_TRUNCATED;
        if (r < 88) return FK_SMALL_LEN;
        if (r < 91) return FK_OVERFLOW;
        return FK_NOISE;
    endfunction

    // called on a rising edge; returns on the edge of the transfer or after the gap
    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        in_ch.valid      <= 1'b1;
        in_ch.byte_value <= b;
        in_ch.last_byte  <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        tracker.note_byte(b, last);
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_buffer(input octet_q_t f);
        foreach (f[i])
            push_byte(f[i], i == f.size() - 1);
    endtask

    task automatic wait_for_reports();
        in_ch.valid <= 1'b0;
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_address(input logic [31:0] value);
        wait_for_reports();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.address = value;
    endtask

    task automatic send_random_buffer();
        octet_q_t    f;
        int unsigned len;
        int unsigned pos;
        logic [31:0] a;
        a   = tracker.address;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(2, 119) : $urandom_range(2, 16);
        f   = build_frame(a, 16'(len), random_bytes(len - 2));
        case (pick_kind())
            FK_GOOD:
                if ($urandom_range(0, 9) == 0)
                    f = {f, random_bytes($urandom_range(1, 6))};
            FK_BAD_SUM:
            begin
                pos = $urandom_range(srfc_pkg::POS_CONFIRM, f.size() - 1);
                f[pos] ^= 8'(1 << $urandom_range(0, 7));
            end
            FK_BAD_HEADER:
            begin
                pos = $urandom_range(0, srfc_pkg::POS_PID);
                f[pos] ^= 8'(1 << $urandom_range(0, 7));
            end
            FK_TRUNCATED:
                f = f[0 : $urandom_range(0, f.size() - 2)];
            FK_SMALL_LEN:
                f = build_frame(a, 16'($urandom_range(0, 1)), random_bytes($urandom_range(0, 6)));
            FK_OVERFLOW:
            begin
                len = $urandom_range(117, 140);
                f   = build_frame(a, 16'(len), random_bytes(len - 2));
                f   = {f, random_bytes($urandom_range(0, 4))};
            end
            FK_NOISE:
            begin
                f = random_bytes($urandom_range(1, 20));
                if ($urandom_range(0, 1) == 1)
                    f[0] = srfc_pkg::HDR0_BYTE;
            end
        endcase
        send_buffer(f);
    endtask

    task automatic send_directed(input logic [31:0] a);
        octet_q_t f;
        send_buffer(build_frame(a, 16'd2, random_bytes(0)));
        send_buffer(build_frame(a, 16'd5, {8'h00, 8'hFF, 8'hFF}));
        send_buffer(build_frame(a, 16'd5, {8'hFF, 8'h00, 8'h00}));
        // short buffers: one byte, 7 and 8 bytes with a good header
        send_buffer({srfc_pkg::HDR0_BYTE});
        f = build_frame(a, 16'd4, random_bytes(2));
        send_buffer(f[0:6]);
        send_buffer(f[0:7]);
        // declared length 0 and 1
        send_buffer(build_frame(a, 16'd0, random_bytes(2)));
        send_buffer(build_frame(a, 16'd1, random_bytes(1)));
        f = build_frame(a, 16'd4, random_bytes(2));
        f[f.size() - 1] ^= 8'h01;
        send_buffer(f);
        send_buffer({build_frame(a, 16'd3, random_bytes(1)), random_bytes(3)});
        f = build_frame(a, 16'd6, random_bytes(4));
        send_buffer(f[0 : f.size() - 2]);
        // fills the buffer; last mark lands on a dropped byte
        send_buffer({build_frame(a, 16'd119, random_bytes(117)), random_bytes(3)});
        send_buffer(build_frame(a, 16'hFFFF, random_bytes(4)));
        f = build_frame(a, 16'd4, random_bytes(2));
        f[srfc_pkg::POS_ADDR0] ^= 8'h80;
        send_buffer(f);
        f = build_frame(a, 16'd4, random_bytes(2));
        f[srfc_pkg::POS_PID] ^= 8'h01;
        send_buffer(f);
    endtask

    initial
    begin
        int unsigned seen;
        int unsigned stall_left;
        int gap;
        seen       = 0;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                tracker.check_report(out_ch.status, out_ch.confirm_code,
                                     out_ch.first_param, out_ch.declared_len);
                seen++;
                if (seen == 20)
                    stall_left = 400;
            end
            if (!rst_n)
                out_ch.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                gap = pick_gap();
                out_ch.ready <= (gap == 0);
                if (gap > 0)
                    stall_left = gap - 1;
            end
        end
    end

    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.byte_value <= '0;
        in_ch.last_byte  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed(tracker.address);
        while (bytes_sent < 600)
            send_random_buffer();

        write_address(32'h0000_0000);
        send_directed(tracker.address);
        while (bytes_sent < 1100)
            send_random_buffer();

        write_address($urandom);
        while (bytes_sent < 1450)
            send_random_buffer();

        write_address(32'hFFFF_FFFF);
        while (bytes_sent < 1850)
            send_random_buffer();

        wait_for_reports();
        repeat (5) @(posedge clk);
        if (tracker.pending() != 0)
            $error("%0d expected results never arrived", tracker.pending());
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
